>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the bit reader checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// assertion on the default clock and reset of this project
`define ASSERT_DEF(name, prop) \
  `ASSERT_CLK_RST(name, clk_i, rst_ni, prop)

`endif

>>> src/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// types and constants of the lsb-first bit reader
// ----------------------------------------------------------------------------
package lbr_pkg;

  // default sizes
  localparam int unsigned LBR_STORE_DEPTH   = 4096;
  localparam int unsigned LBR_MAX_READ_BITS = 24;

  // fixed field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned BITS_W  = 24;
  localparam int unsigned OFF_W   = 3;
  localparam int unsigned LEN_W   = 13;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_READ   = 3'd1,
    FUNC_PEEK   = 3'd2,
    FUNC_SKIP   = 3'd3,
    FUNC_SETPOS = 3'd4
  } lbr_func_e;

  // register index of data_length
  localparam logic REG_DATA_LENGTH = 1'b0;

  // input word
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  load_address;
    logic [7:0]         load_byte;
    logic [COUNT_W-1:0] bit_count;
    logic [ADDR_W-1:0]  new_position;
  } lbr_in_t;

  // result word
  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic [POS_W-1:0]  byte_position;
    logic [OFF_W-1:0]  bit_offset;
  } lbr_out_t;

endpackage

>>> src/lbr_bank.sv
// ----------------------------------------------------------------------------
// lbr_bank
// one byte bank: single write port, single read port, registered read data
// ----------------------------------------------------------------------------
module lbr_bank #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ROW_W  = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ROW_W-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [ROW_W-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lsb_first_bit_reader_core.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_reader_core
// little-endian lsb-first bit reader over a four-bank byte store
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-----------
//  input    | in_valid_i in_ready_o in_data_i  | in        | lbr_in_t
//  output   | out_valid_o out_ready_i out_data_o| out       | lbr_out_t
//  config   | psel penable pwrite paddr pwdata | in        | data_length
//
//  one word per cycle while the output is not stalled; an accepted word is read
//  from the banks into the read stage, then extracted into the output register
//  the four banks give the whole 32-bit window in one read
//  position and offset update in the accept cycle, so the next word follows
//  no clearing pass after reset: store bytes are undefined until loaded
//  a stalled output holds the word in the read stage, then stops input
// ----------------------------------------------------------------------------
module lsb_first_bit_reader_core
  import lbr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH   = LBR_STORE_DEPTH,
  parameter int unsigned MAX_READ_BITS = LBR_MAX_READ_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lbr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lbr_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned BANK_DEPTH = (STORE_DEPTH + 3) / 4;
  localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [31:0] DEPTH32    = 32'(STORE_DEPTH);
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_READ_BITS);

  // saturating position add
  function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] base,
                                               logic [2:0] inc);
    logic [31:0] s;
    s = 32'(base) + 32'(inc);
    return (s > DEPTH32) ? POS_W'(STORE_DEPTH) : s[POS_W-1:0];
  endfunction

  // config register
  logic [LEN_W-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DATA_LENGTH) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DATA_LENGTH) ? 32'(len_q) : 32'd0;

  // handshake and stage control
  logic accept;
  logic out_free;
  logic s1_valid_q, s1_valid_d;
  logic s1_move;
  logic out_valid_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  // position state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [2:0]       phase_q, phase_d;
  logic [COUNT_W-1:0] count_sat;
  logic [5:0]       phase_sum;
  logic             is_read;

  assign count_sat = (in_data_i.bit_count > MAX_CNT) ? MAX_CNT : in_data_i.bit_count;
  assign phase_sum = {3'b000, phase_q} + {1'b0, count_sat};
  assign is_read   = (in_data_i.func == FUNC_READ) || (in_data_i.func == FUNC_PEEK);

  // next position and offset
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    if (accept) begin
      case (in_data_i.func)
        FUNC_READ: begin
          phase_d = phase_sum[2:0];
          pos_d   = sat_add(pos_q, phase_sum[5:3]);
        end
        FUNC_SKIP: begin
          if (phase_q != 3'd0) begin
            phase_d = 3'd0;
            pos_d   = sat_add(pos_q, 3'd1);
          end
        end
        FUNC_SETPOS: begin
          phase_d = 3'd0;
          pos_d   = (32'(in_data_i.new_position) > DEPTH32) ?
                    POS_W'(STORE_DEPTH) : POS_W'(in_data_i.new_position);
        end
        default: begin
          pos_d   = pos_q;
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // window byte range check against length and depth
  logic [3:0] byte_ok;

  always_comb begin
    logic [31:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx        = 32'(pos_q) + 32'(k);
      byte_ok[k] = (idx < 32'(len_q)) && (idx < DEPTH32);
    end
  end

  // bank addressing: bank b holds bytes whose low two address bits equal b
  logic [ROW_W-1:0] rd_row [4];
  logic [ROW_W-1:0] wr_row;
  logic [3:0]       bank_we;
  logic             bank_re;
  logic [7:0]       rd_data [4];

  always_comb begin
    logic [31:0] row;
    for (int b = 0; b < 4; b++) begin
      row       = 32'(pos_q >> 2) + ((2'(b) < pos_q[1:0]) ? 32'd1 : 32'd0);
      rd_row[b] = row[ROW_W-1:0];
    end
  end

  assign wr_row  = ROW_W'(in_data_i.load_address >> 2);
  assign bank_re = accept && is_read;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = accept && (in_data_i.func == FUNC_LOAD) &&
                   (32'(in_data_i.load_address) < DEPTH32) &&
                   (in_data_i.load_address[1:0] == 2'(b));
    end
  end

  // four byte banks
  for (genvar g = 0; g < 4; g++) begin : g_bank
    lbr_bank #(
      .DEPTH (BANK_DEPTH),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (wr_row),
      .wdata_i (in_data_i.load_byte),
      .re_i    (bank_re),
      .raddr_i (rd_row[g]),
      .rdata_o (rd_data[g])
    );
  end

  // read stage registers
  logic               s1_read_q;
  logic [COUNT_W-1:0] s1_count_q;
  logic [2:0]         s1_phase_q;
  logic [1:0]         s1_rot_q;
  logic [3:0]         s1_ok_q;
  logic [POS_W-1:0]   s1_pos_q;
  logic [2:0]         s1_off_q;

  assign s1_valid_d = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q  <= is_read;
      s1_count_q <= count_sat;
      s1_phase_q <= phase_q;
      s1_rot_q   <= pos_q[1:0];
      s1_ok_q    <= byte_ok;
      s1_pos_q   <= pos_d;
      s1_off_q   <= phase_d;
    end
  end

  // window assembly and extract
  logic [31:0] window;
  logic [31:0] shifted;
  logic [31:0] mask;
  logic [31:0] extracted;

  always_comb begin
    logic [1:0] bsel;
    for (int k = 0; k < 4; k++) begin
      bsel = s1_rot_q + 2'(k);
      window[8*k +: 8] = s1_ok_q[k] ? rd_data[bsel] : 8'd0;
    end
  end

  assign shifted   = window >> s1_phase_q;
  assign mask      = (32'd1 << s1_count_q) - 32'd1;
  assign extracted = s1_read_q ? (shifted & mask) : 32'd0;

  // output register
  lbr_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.bits          <= extracted[BITS_W-1:0];
      out_q.byte_position <= s1_pos_q;
      out_q.bit_offset    <= s1_off_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/lbr_port_chk.sv
// ----------------------------------------------------------------------------
// lbr_port_chk
// port-level checks of the bit reader, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbr_port_chk
  import lbr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = LBR_STORE_DEPTH
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input lbr_out_t out_data_o,
  input logic     pready
);

  localparam logic [31:0] DEPTH32 = 32'(STORE_DEPTH);

  // a stalled result word holds
  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // position never passes the store depth
  `ASSERT_DEF(a_pos_sat, out_valid_o |-> 32'(out_data_o.byte_position) <= DEPTH32)

  // input is only held off by a stalled output
  `ASSERT_DEF(a_ready_when_drain, out_ready_i |-> in_ready_o)

  // an accepted word shows up at the output, through the read stage and the output register
  `ASSERT_DEF(a_latency, in_valid_i && in_ready_o |-> ##2 out_valid_o)

  // config port never waits
  `ASSERT_DEF(a_pready, pready)

endmodule

bind lsb_first_bit_reader_core lbr_port_chk #(
  .STORE_DEPTH (STORE_DEPTH)
) u_lbr_port_chk (.*);

>>> dv/lbr_bit_reader_checker.sv
// ----------------------------------------------------------------------------
// lbr_bit_reader_checker
// watches the word channels and the config port of the lsb-first bit reader,
// predicts every result word from a shadow of the store, the position and the
// length register, and compares each accepted result field by field
// ----------------------------------------------------------------------------
module lbr_bit_reader_checker
  import lbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  lbr_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  lbr_out_t    out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int unsigned words_pending_o,
  output int unsigned mismatch_count_o
);

  // shadow state of the reader
  logic [7:0]       shadow_store [LBR_STORE_DEPTH];
  logic [POS_W-1:0] cur_position;
  logic [OFF_W-1:0] cur_offset;
  logic [LEN_W-1:0] cur_length;
  lbr_out_t         expected_words [$];
  int unsigned      mismatch_count;

  assign mismatch_count_o = mismatch_count;

  // one line per mismatch, every one counted
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // bytes at or past the length or the store end read as zero
  function automatic logic [7:0] window_byte(int unsigned idx);
    if (idx >= cur_length || idx >= LBR_STORE_DEPTH) return 8'h00;
    return shadow_store[idx];
  endfunction

  // byte position never passes the store depth
  function automatic logic [POS_W-1:0] clamp_position(int unsigned pos);
    return (pos > LBR_STORE_DEPTH) ? POS_W'(LBR_STORE_DEPTH) : POS_W'(pos);
  endfunction

  // apply one input word to the shadow state and return its result word
  function automatic lbr_out_t predict_reader_step(lbr_in_t w);
    lbr_out_t    res;
    int unsigned count;
    int unsigned phase;
    int unsigned k;
    logic [63:0] window;
    logic [63:0] mask;
    count  = (w.bit_count > LBR_MAX_READ_BITS) ? LBR_MAX_READ_BITS : w.bit_count;
    window = '0;
    for (k = 0; k < 4; k++) begin
      window |= 64'(window_byte(cur_position + k)) << (8 * k);
    end
    mask     = ((64'd1 << count) - 64'd1) << cur_offset;
    res.bits = '0;
    case (w.func)
      FUNC_LOAD: begin
        shadow_store[w.load_address] = w.load_byte;
      end
      FUNC_READ: begin
        res.bits     = BITS_W'((window & mask) >> cur_offset);
        phase        = cur_offset + count;
        cur_position = clamp_position(cur_position + (phase >> 3));
        cur_offset   = OFF_W'(phase);
      end
      FUNC_PEEK: begin
        res.bits = BITS_W'((window & mask) >> cur_offset);
      end
      FUNC_SKIP: begin
        if (cur_offset != '0) begin
          cur_offset   = '0;
          cur_position = clamp_position(cur_position + 1);
        end
      end
      FUNC_SETPOS: begin
        cur_position = clamp_position(w.new_position);
        cur_offset   = '0;
      end
      default: ;
    endcase
    res.byte_position = cur_position;
    res.bit_offset    = cur_offset;
    return res;
  endfunction

  // compare leaving words, predict entering words, track the length register
  always @(posedge clk_i or negedge rst_ni) begin
    lbr_out_t want;
    if (!rst_ni) begin
      cur_position    = '0;
      cur_offset      = '0;
      cur_length      = '0;
      mismatch_count  = 0;
      expected_words.delete();
      words_pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && (paddr_i >> 2) == REG_DATA_LENGTH) begin
        cur_length = pwdata_i[LEN_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected, bits", 32'(out_data_i.bits), '0);
        end else begin
          want = expected_words.pop_front();
          if (out_data_i.bits !== want.bits) begin
            report_mismatch("bits", 32'(out_data_i.bits), 32'(want.bits));
          end
          if (out_data_i.byte_position !== want.byte_position) begin
            report_mismatch("byte_position", 32'(out_data_i.byte_position),
                            32'(want.byte_position));
          end
          if (out_data_i.bit_offset !== want.bit_offset) begin
            report_mismatch("bit_offset", 32'(out_data_i.bit_offset), 32'(want.bit_offset));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_words.push_back(predict_reader_step(in_data_i));
      end
      words_pending_o <= expected_words.size();
    end
  end

endmodule

>>> dv/tb_lsb_first_bit_reader_core.sv
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_reader_core
// drives the lsb-first bit reader with directed corner words and random word
// streams over several length settings, with random idling on both channels
// and one long output hold-off; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_reader_core;
  import lbr_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned LIMIT_TIME  = 4_000_000;
  localparam int unsigned DRAIN_SLACK = 8;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned PHASE_WORDS = 110;
  localparam int unsigned NUM_PHASES  = 6;
  // bytes loaded up front; no length setting reaches past them
  localparam int unsigned FILL_BYTES  = 256;

  // func codes the block treats as no-ops
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  lbr_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lbr_out_t    out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned words_pending;
  int unsigned mismatch_count;

  // idling controls for the sender and the receiver
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_request   = 1'b0;

  lsb_first_bit_reader_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  lbr_bit_reader_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .words_pending_o  (words_pending),
    .mismatch_count_o (mismatch_count)
  );

  // clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("simulation failed");
    $finish;
  end

  // output side: short random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left--;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // word with the given op, count and position; load fields random
  function automatic lbr_in_t make_word(logic [FUNC_W-1:0] func, int unsigned count,
                                        int unsigned pos);
    lbr_in_t w;
    w.func         = func;
    w.load_address = ADDR_W'($urandom);
    w.load_byte    = 8'($urandom);
    w.bit_count    = COUNT_W'(count);
    w.new_position = ADDR_W'(pos);
    return w;
  endfunction

  // mostly reads and peeks, with jumps, skips, loads and spare codes mixed in
  function automatic lbr_in_t random_word();
    lbr_in_t     w;
    int unsigned pick;
    w.load_address = ADDR_W'($urandom);
    w.load_byte    = 8'($urandom);
    w.bit_count    = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(25, 31))
                                                 : COUNT_W'($urandom_range(0, 24));
    w.new_position = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom_range(4086, 4095))
                                                 : ADDR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45)      w.func = FUNC_READ;
    else if (pick < 60) w.func = FUNC_PEEK;
    else if (pick < 68) w.func = FUNC_SKIP;
    else if (pick < 80) w.func = FUNC_SETPOS;
    else if (pick < 92) w.func = FUNC_LOAD;
    else if (pick < 95) w.func = FUNC_SPARE_A;
    else if (pick < 98) w.func = FUNC_SPARE_B;
    else                w.func = FUNC_SPARE_C;
    return w;
  endfunction

  // offer one word and wait for it to be taken, then maybe idle a burst
  task automatic send_word(lbr_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected word has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  // config write: setup cycle, then access cycle
  task automatic write_length(int unsigned len);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_DATA_LENGTH, 2'b00};
    pwdata  <= 32'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    lbr_in_t     w;
    int unsigned phase_length [NUM_PHASES];
    int unsigned i;
    int unsigned p;

    phase_length = '{FILL_BYTES, 0, 1, FILL_BYTES - 3,
                     $urandom_range(0, FILL_BYTES), $urandom_range(1, 64)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store after reset: everything reads as zero, saturation at the end
    send_word(make_word(FUNC_READ, LBR_MAX_READ_BITS, 0));
    send_word(make_word(FUNC_PEEK, 31, 0));
    send_word(make_word(FUNC_SKIP, 0, 0));
    send_word(make_word(FUNC_READ, 3, 0));
    send_word(make_word(FUNC_SKIP, 0, 0));
    send_word(make_word(FUNC_SPARE_A, 9, 0));
    send_word(make_word(FUNC_SPARE_B, 9, 0));
    send_word(make_word(FUNC_SPARE_C, 9, 0));
    send_word(make_word(FUNC_SETPOS, 0, LBR_STORE_DEPTH - 1));
    send_word(make_word(FUNC_READ, 9, 0));
    send_word(make_word(FUNC_READ, 31, 0));
    send_word(make_word(FUNC_SKIP, 0, 0));
    send_word(make_word(FUNC_SETPOS, 0, 0));

    // fill the low part of the store so that no read ever sees an unloaded byte
    for (i = 0; i < FILL_BYTES; i++) begin
      w              = make_word(FUNC_LOAD, $urandom_range(0, 31), $urandom);
      w.load_address = ADDR_W'(i);
      if (i == 0) w.load_byte = 8'hFF;
      if (i == 1) w.load_byte = 8'h00;
      send_word(w);
    end
    wait_drained();
    write_length(FILL_BYTES);

    // filled length: zero and long counts, skips, reads across the store end
    send_word(make_word(FUNC_SETPOS, 0, 0));
    send_word(make_word(FUNC_READ, 0, 0));
    send_word(make_word(FUNC_READ, 1, 0));
    send_word(make_word(FUNC_READ, 7, 0));
    send_word(make_word(FUNC_PEEK, LBR_MAX_READ_BITS, 0));
    send_word(make_word(FUNC_READ, 30, 0));
    send_word(make_word(FUNC_READ, 5, 0));
    send_word(make_word(FUNC_SKIP, 0, 0));
    send_word(make_word(FUNC_SETPOS, 0, LBR_STORE_DEPTH - 2));
    send_word(make_word(FUNC_PEEK, LBR_MAX_READ_BITS, 0));
    send_word(make_word(FUNC_READ, 17, 0));
    w              = make_word(FUNC_LOAD, 0, 0);
    w.load_address = ADDR_W'(LBR_STORE_DEPTH - 1);
    send_word(w);
    wait_drained();
    write_length(5);

    // short length: window straddles the last valid byte
    send_word(make_word(FUNC_SETPOS, 0, 3));
    send_word(make_word(FUNC_PEEK, LBR_MAX_READ_BITS, 0));
    send_word(make_word(FUNC_READ, 12, 0));
    send_word(make_word(FUNC_READ, LBR_MAX_READ_BITS, 0));

    // random streams, one per length setting; the last one runs without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_length(phase_length[p]);
      if (p == NUM_PHASES - 1) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      for (i = 0; i < PHASE_WORDS; i++) begin
        // long output hold-off while words keep coming, so the input stalls
        if (p == 2 && i == 40) begin
          hold_request = 1'b1;
          sender_idles = 1'b0;
        end
        if (p == 2 && i == 70) sender_idles = 1'b1;
        send_word(random_word());
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/lbr_pkg.sv
src/lbr_bank.sv
src/lsb_first_bit_reader_core.sv
src/lbr_port_chk.sv
dv/lbr_bit_reader_checker.sv
dv/tb_lsb_first_bit_reader_core.sv
